FILE: src/r2fft_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// r2fft_pkg: shared types and constants for the radix-2 FFT
// Sample and bin widths, the packed store word and the quarter-wave sine table.
// ----------------------------------------------------------------------------
package r2fft_pkg;

  localparam int SampleW = 16;
  localparam int BinW    = 22;
  localparam int TwW     = 16;
  localparam int MaxLogN = 6;

  localparam logic signed [BinW-1:0] SatMax = 22'sh1FFFFF;
  localparam logic signed [BinW-1:0] SatMin = 22'sh200000;

  typedef struct packed {
    logic signed [BinW-1:0] im;
    logic signed [BinW-1:0] re;
  } cword_t;

  // round(32768*sin(pi*k/64)), k = 0..32, top entry saturated
  function automatic logic [TwW-1:0] quarter_sine(input logic [5:0] k);
    logic [TwW-1:0] v;
    unique case (k)
      6'd0: v = 16'd0;      6'd1: v = 16'd1608;   6'd2: v = 16'd3212;
      6'd3: v = 16'd4808;   6'd4: v = 16'd6393;   6'd5: v = 16'd7962;
      6'd6: v = 16'd9512;   6'd7: v = 16'd11039;  6'd8: v = 16'd12540;
      6'd9: v = 16'd14010;  6'd10: v = 16'd15447; 6'd11: v = 16'd16846;
      6'd12: v = 16'd18205; 6'd13: v = 16'd19520; 6'd14: v = 16'd20788;
      6'd15: v = 16'd22006; 6'd16: v = 16'd23170; 6'd17: v = 16'd24279;
      6'd18: v = 16'd25330; 6'd19: v = 16'd26320; 6'd20: v = 16'd27246;
      6'd21: v = 16'd28106; 6'd22: v = 16'd28899; 6'd23: v = 16'd29622;
      6'd24: v = 16'd30274; 6'd25: v = 16'd30853; 6'd26: v = 16'd31357;
      6'd27: v = 16'd31786; 6'd28: v = 16'd32138; 6'd29: v = 16'd32413;
      6'd30: v = 16'd32610; 6'd31: v = 16'd32729; 6'd32: v = 16'd32767;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [BinW-1:0] sat22(input logic signed [BinW+1:0] v);
    logic signed [BinW-1:0] r;
    if (v > $signed({{2{SatMax[BinW-1]}}, SatMax})) r = SatMax;
    else if (v < $signed({{2{SatMin[BinW-1]}}, SatMin})) r = SatMin;
    else r = v[BinW-1:0];
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: src/r2fft_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// r2fft_ram: generic single-port RAM
// One write or one read per cycle, registered read data.
// ----------------------------------------------------------------------------
module r2fft_ram #(
  parameter int WIDTH = 44,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

FILE: src/radix2_fft.sv
`timescale 1ns / 1ps
`default_nettype none
// Load: one sample per cycle while a frame fills (RAM writes for the first P).
// Transform: (P/2)*log2(P) butterflies, each in turn on one shared multiplier
//   and one single-port store (P = largest power of two not above POINTS).
// Emit: each bin is read via the same RAM port into the output register.
// Reset clears the sequencer and counters; the store is not cleared.
// ----------------------------------------------------------------------------
// radix2_fft: frame-based forward radix-2 DIT FFT
// Iterative in-place FFT with one shared complex butterfly multiplier.
// ----------------------------------------------------------------------------
module radix2_fft #(
  parameter int POINTS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // [15:0] sample_re, [31:16] sample_im
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [47:0]      m_tdata,   // [21:0] bin_re, [43:22] bin_im, zero fill
  output logic             m_tlast    // last_bin
);
  localparam int BinW = r2fft_pkg::BinW;
  localparam int LogN = $clog2(POINTS + 1) - 1;   // floor(log2(POINTS))
  localparam int FftN = 1 << LogN;
  localparam int AW   = (POINTS > 1) ? $clog2(POINTS) : 1;
  localparam int CW   = $clog2(POINTS + 1);
  localparam int SW   = $clog2(r2fft_pkg::MaxLogN + 1);

  typedef enum logic [8:0] {
    S_LOAD  = 9'b000000001,
    S_RDB   = 9'b000000010,
    S_RDA   = 9'b000000100,
    S_MUL1  = 9'b000001000,
    S_MUL2  = 9'b000010000,
    S_SUM   = 9'b000100000,
    S_WRA   = 9'b001000000,
    S_WRB   = 9'b010000000,
    S_EMIT  = 9'b100000000
  } state_t;

  state_t state;
  logic [CW-1:0] cnt;          // sample count, butterfly k, bin index
  logic [AW-1:0] base;
  logic [SW-1:0] stage;        // h = 1 << stage
  logic          emit_rd;      // read issued for current bin
  logic          out_full;

  logic          ram_we;
  logic [AW-1:0] ram_addr;
  r2fft_pkg::cword_t ram_wdata, ram_rdata;

  r2fft_ram #(.WIDTH(2 * BinW), .DEPTH(1 << AW)) u_store (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  // bit reverse over LogN bits
  logic [AW-1:0] rev_addr;
  always_comb begin
    rev_addr = '0;
    for (int i = 0; i < LogN; i++) rev_addr[LogN-1-i] = cnt[i];
  end

  logic [AW:0] h_val;
  logic [AW-1:0] a_addr, b_addr;
  logic [5:0] tw_idx;
  assign h_val  = (AW+1)'(1) << stage;
  assign a_addr = AW'(base + AW'(cnt));
  assign b_addr = AW'(a_addr + AW'(h_val));
  assign tw_idx = 6'((7'(cnt) << (r2fft_pkg::MaxLogN - stage)));

  // twiddle parts: w = c - j s
  logic signed [16:0] tw_c, tw_s;
  always_comb begin
    if (tw_idx <= 6'd32) begin
      tw_c = $signed({1'b0, r2fft_pkg::quarter_sine(6'(6'd32 - tw_idx))});
      tw_s = $signed({1'b0, r2fft_pkg::quarter_sine(tw_idx)});
    end else begin
      tw_c = -$signed({1'b0, r2fft_pkg::quarter_sine(6'(tw_idx - 6'd32))});
      tw_s = $signed({1'b0, r2fft_pkg::quarter_sine(6'(7'd64 - 7'(tw_idx)))});
    end
  end

  // shared multiplier, two products per cycle, in states MUL1 and MUL2
  logic signed [BinW-1:0] xr, xi, ar, ai;
  logic signed [39:0] p0, p1, tr_acc, ti_acc;
  logic signed [BinW+1:0] tr, ti;
  logic signed [BinW-1:0] mul_x0, mul_x1;
  logic signed [16:0] mul_w0, mul_w1;
  always_comb begin
    if (state == S_MUL1) begin
      mul_w0 = tw_c; mul_x0 = xr; mul_w1 = tw_s; mul_x1 = xi;
    end else begin
      mul_w0 = tw_c; mul_x0 = xi; mul_w1 = -tw_s; mul_x1 = xr;
    end
  end
  assign p0 = 40'(mul_w0 * mul_x0);
  assign p1 = 40'(mul_w1 * mul_x1);

  always_comb begin
    ram_we = 1'b0;
    ram_addr = a_addr;
    ram_wdata = '{re: ar, im: ai};
    unique case (state)
      S_LOAD: begin
        ram_we = s_tvalid && (cnt < CW'(FftN));
        ram_addr = rev_addr;
        ram_wdata = '{re: BinW'(signed'(s_tdata[15:0])), im: BinW'(signed'(s_tdata[31:16]))};
      end
      S_RDB:  ram_addr = b_addr;
      S_RDA, S_MUL1, S_MUL2, S_SUM: ram_addr = a_addr;
      S_WRA: begin
        ram_we = 1'b1;
        ram_wdata = '{re: r2fft_pkg::sat22(24'(ar) + tr), im: r2fft_pkg::sat22(24'(ai) + ti)};
      end
      S_WRB: begin
        ram_we = 1'b1;
        ram_addr = b_addr;
        ram_wdata = '{re: r2fft_pkg::sat22(24'(ar) - tr), im: r2fft_pkg::sat22(24'(ai) - ti)};
      end
      S_EMIT: ram_addr = AW'(cnt);
      default: ram_addr = a_addr;
    endcase
  end

  assign s_tready = (state == S_LOAD);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      cnt <= '0; base <= '0; stage <= '0;
      emit_rd <= 1'b0; out_full <= 1'b0; m_tlast <= 1'b0;
    end else begin
      if (out_full && m_tready) out_full <= 1'b0;
      unique case (state)
        S_LOAD: if (s_tvalid) begin
          if (cnt == CW'(POINTS - 1)) begin
            cnt <= '0; base <= '0; stage <= '0;
            state <= (LogN > 0) ? S_RDB : S_EMIT;
          end else cnt <= CW'(cnt + 1'b1);
        end
        S_RDB:  state <= S_RDA;
        S_RDA:  begin xr <= ram_rdata.re; xi <= ram_rdata.im; state <= S_MUL1; end
        S_MUL1: begin
          ar <= ram_rdata.re; ai <= ram_rdata.im;
          tr_acc <= p0 + p1 + 40'sd16384; state <= S_MUL2;
        end
        S_MUL2: begin ti_acc <= p0 + p1 + 40'sd16384; state <= S_SUM; end
        S_SUM: begin
          tr <= (BinW+2)'(tr_acc >>> 15); ti <= (BinW+2)'(ti_acc >>> 15);
          state <= S_WRA;
        end
        S_WRA: state <= S_WRB;
        S_WRB: begin
          state <= S_RDB;
          if (CW'(cnt + 1'b1) == CW'(h_val)) begin
            cnt <= '0;
            if (32'(base) + 32'(h_val) * 2 >= FftN) begin
              base <= '0;
              if (32'(stage) + 1 == LogN) begin
                stage <= '0; state <= S_EMIT;
              end else stage <= SW'(stage + 1'b1);
            end else base <= AW'(base + AW'(h_val << 1));
          end else cnt <= CW'(cnt + 1'b1);
        end
        S_EMIT: begin
          if (!emit_rd) begin
            if (!out_full || m_tready) emit_rd <= 1'b1;
          end else begin
            emit_rd <= 1'b0;
            out_full <= 1'b1;
            m_tdata <= (cnt < CW'(FftN)) ? {4'b0, ram_rdata.im, ram_rdata.re} : '0;
            m_tlast <= (cnt == CW'(POINTS - 1));
            if (cnt == CW'(POINTS - 1)) begin
              cnt <= '0; state <= S_LOAD;
            end else cnt <= CW'(cnt + 1'b1);
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  assign m_tvalid = out_full;

  a_no_load_busy: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> (state == S_LOAD)) else $error("ready outside load");
  a_emit_no_drop: assert property (@(posedge clk) disable iff (rst)
    (out_full && !m_tready) |=> out_full) else $error("bin dropped");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> ($stable(m_tdata) && $stable(m_tlast)))
    else $error("bin changed while waiting");
endmodule
`default_nettype wire
